@@ rtl/core/gbn_pkg.sv @@
// Package for the Go-Back-N sender window controller.
// Holds widths, register indexes, the sequencer state type and shared structs.
// Has no dependencies; used by gbn_seq_unit and go_back_n_sender_window.
package gbn_pkg;

	localparam int SEQ_BITS   = 16;
	localparam int MAX_WINDOW = 64;
	localparam int CNT_BITS   = $clog2(MAX_WINDOW);
	localparam int WIN_BITS   = 7;
	localparam int TICK_BITS  = 16;
	localparam int RETRY_BITS = 8;
	localparam int TOC_BITS   = 9;
	localparam int CFG_BITS   = 16;

	// Reset values of the configuration registers
	localparam logic [SEQ_BITS-1:0]   PACKET_COUNT_RST  = '0;
	localparam logic [WIN_BITS-1:0]   WINDOW_SIZE_RST   = WIN_BITS'(8);
	localparam logic [TICK_BITS-1:0]  TIMEOUT_TICKS_RST = TICK_BITS'(100);
	localparam logic [RETRY_BITS-1:0] RETRY_LIMIT_RST   = RETRY_BITS'(10);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PACKET_COUNT  = 2'd0,
		REG_WINDOW_SIZE   = 2'd1,
		REG_TIMEOUT_TICKS = 2'd2,
		REG_RETRY_LIMIT   = 2'd3
	} cfg_reg_t;

	// Input op codes
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_ACK  = 1'b1
	} op_t;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_RESEND = 3'b010,
		ST_SEND   = 3'b100
	} state_t;

	// Step result from the shared sequence unit
	typedef struct packed {
		logic [SEQ_BITS-1:0] seq_inc;
		logic                last;
	} seq_step_t;

endpackage

@@ rtl/core/gbn_seq_unit.sv @@
// Shared sequence step unit: advances a sequence cursor toward a bound.
// Flags the final step of a burst by bound or by the per-item command limit.
// Depends on gbn_pkg.
module gbn_seq_unit (
	input  logic [gbn_pkg::SEQ_BITS-1:0] cursor,
	input  logic [gbn_pkg::SEQ_BITS:0]   bound,
	input  logic [gbn_pkg::CNT_BITS-1:0] cnt,
	output gbn_pkg::seq_step_t           step
);

	logic [gbn_pkg::SEQ_BITS:0] inc_w;

	// One increment and one compare against the bound
	always_comb begin
		inc_w        = {1'b0, cursor} + (gbn_pkg::SEQ_BITS+1)'(1);
		step.seq_inc = inc_w[gbn_pkg::SEQ_BITS-1:0];
		step.last    = (inc_w >= bound) ||
			(cnt == gbn_pkg::CNT_BITS'(gbn_pkg::MAX_WINDOW - 1));
	end

endmodule

@@ rtl/core/go_back_n_sender_window.sv @@
// Go-Back-N sender window controller: top level with sequencer and output register.
// Depends on gbn_pkg and gbn_seq_unit.
//
// Each input transaction is either a tick (op 0) or an acknowledgement (op 1) and
// yields one or more result transactions; the final one carries last. An
// acknowledgement, a tick that sends nothing, or any tick once the transfer is
// done or failed, yields one status result in the cycle after acceptance. A tick
// that times out emits resend commands for window_base..next_seq-1, and a tick
// with room in the window emits send commands for new sequences; either burst
// comes out one command per cycle while the output is not stalled, through the shared
// sequence step unit; the sequencer state is registered first, then each command in
// the output register. A burst holds at most 64 commands. in_ready is high only in
// the idle state while the output register is empty or being taken, so the next
// item is accepted no earlier than the cycle in which the last result of the
// current item is taken.
// Configuration writes take effect at once and are meant for idle periods.
module go_back_n_sender_window (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [gbn_pkg::CFG_BITS-1:0]    cfg_wdata,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [gbn_pkg::SEQ_BITS-1:0]    ack_number,
	input  logic                            ack_ok,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            send_valid,
	output logic [gbn_pkg::SEQ_BITS-1:0]    send_seq,
	output logic                            is_resend,
	output logic                            last,
	output logic                            done_res,
	output logic                            failed
);

	localparam int SB = gbn_pkg::SEQ_BITS;

	// configuration registers
	logic [SB-1:0]                    packet_count_q;
	logic [gbn_pkg::WIN_BITS-1:0]     window_size_q;
	logic [gbn_pkg::TICK_BITS-1:0]    timeout_ticks_q;
	logic [gbn_pkg::RETRY_BITS-1:0]   retry_limit_q;

	// window state
	logic [SB-1:0]                    window_base_q;
	logic [SB-1:0]                    next_seq_q;
	logic [gbn_pkg::TICK_BITS-1:0]    idle_timer_q;
	logic [gbn_pkg::TOC_BITS-1:0]     timeout_count_q;
	logic                             failed_flag_q;

	// sequencer
	gbn_pkg::state_t                  state_q;
	logic [SB-1:0]                    cursor_q;
	logic [SB:0]                      bound_q;
	logic [gbn_pkg::CNT_BITS-1:0]     cnt_q;

	// output register
	logic                             out_valid_q;
	logic                             send_valid_q;
	logic [SB-1:0]                    send_seq_q;
	logic                             is_resend_q;
	logic                             last_q;
	logic                             done_q;
	logic                             failed_q;

	logic                             out_free;
	logic                             accept;

	// ack path
	logic                             ack_take;
	logic [SB:0]                      ack_inc;
	logic [SB-1:0]                    ack_nb;
	logic                             ack_moves;
	logic [SB-1:0]                    base_after_ack;

	// tick path
	logic                             tick_active;
	logic                             outstanding;
	logic [gbn_pkg::TICK_BITS-1:0]    timer_inc;
	logic [gbn_pkg::TICK_BITS-1:0]    tick_lim;
	logic                             expired;
	logic [gbn_pkg::WIN_BITS-1:0]     eff_win;
	logic [SB:0]                      win_top;
	logic [SB:0]                      send_bound;
	logic                             can_send;
	logic [gbn_pkg::TOC_BITS-1:0]     toc_inc;

	// shared step unit
	logic [SB-1:0]                    step_cursor;
	gbn_pkg::seq_step_t               step;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == gbn_pkg::ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	// acknowledgement evaluation; a tick never moves the base
	always_comb begin
		ack_take  = (gbn_pkg::op_t'(op) == gbn_pkg::OP_ACK) && !failed_flag_q && ack_ok
			&& (ack_number >= window_base_q);
		ack_inc   = {1'b0, ack_number} + (SB+1)'(1);
		ack_nb    = (ack_inc > {1'b0, packet_count_q}) ? packet_count_q : ack_inc[SB-1:0];
		ack_moves = ack_take && (ack_nb > window_base_q);
		base_after_ack = ack_moves ? ack_nb : window_base_q;
	end

	// tick evaluation: timer, timeout and send bound
	always_comb begin
		tick_active = !failed_flag_q && (window_base_q < packet_count_q);
		outstanding = next_seq_q > window_base_q;
		timer_inc   = (idle_timer_q == '1) ? idle_timer_q
			: idle_timer_q + gbn_pkg::TICK_BITS'(1);
		tick_lim    = (timeout_ticks_q == '0) ? gbn_pkg::TICK_BITS'(1) : timeout_ticks_q;
		expired     = tick_active && outstanding && (timer_inc >= tick_lim);
		if (window_size_q == '0) begin
			eff_win = gbn_pkg::WIN_BITS'(1);
		end else if (window_size_q > gbn_pkg::WIN_BITS'(gbn_pkg::MAX_WINDOW)) begin
			eff_win = gbn_pkg::WIN_BITS'(gbn_pkg::MAX_WINDOW);
		end else begin
			eff_win = window_size_q;
		end
		win_top    = {1'b0, window_base_q} + (SB+1)'(eff_win);
		send_bound = (win_top > {1'b0, packet_count_q}) ? {1'b0, packet_count_q} : win_top;
		can_send   = tick_active && !expired && ({1'b0, next_seq_q} < send_bound);
		toc_inc    = (timeout_count_q == '1) ? timeout_count_q
			: timeout_count_q + gbn_pkg::TOC_BITS'(1);
	end

	// cursor feeding the shared unit
	assign step_cursor = (state_q == gbn_pkg::ST_SEND) ? next_seq_q : cursor_q;

	gbn_seq_unit u_seq (
		.cursor (step_cursor),
		.bound  (bound_q),
		.cnt    (cnt_q),
		.step   (step)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_count_q  <= gbn_pkg::PACKET_COUNT_RST;
			window_size_q   <= gbn_pkg::WINDOW_SIZE_RST;
			timeout_ticks_q <= gbn_pkg::TIMEOUT_TICKS_RST;
			retry_limit_q   <= gbn_pkg::RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			case (gbn_pkg::cfg_reg_t'(cfg_index))
				gbn_pkg::REG_PACKET_COUNT:  packet_count_q  <= cfg_wdata[SB-1:0];
				gbn_pkg::REG_WINDOW_SIZE:   window_size_q   <= cfg_wdata[gbn_pkg::WIN_BITS-1:0];
				gbn_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata[gbn_pkg::TICK_BITS-1:0];
				gbn_pkg::REG_RETRY_LIMIT:   retry_limit_q   <= cfg_wdata[gbn_pkg::RETRY_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= gbn_pkg::ST_IDLE;
			window_base_q   <= '0;
			next_seq_q      <= '0;
			idle_timer_q    <= '0;
			timeout_count_q <= '0;
			failed_flag_q   <= 1'b0;
			cursor_q        <= '0;
			bound_q         <= '0;
			cnt_q           <= '0;
		end else begin
			case (state_q)
				gbn_pkg::ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (gbn_pkg::op_t'(op) == gbn_pkg::OP_ACK) begin
							if (ack_moves) begin
								window_base_q <= ack_nb;
								idle_timer_q  <= '0;
							end
							if (ack_take && (next_seq_q < base_after_ack)) begin
								next_seq_q <= base_after_ack;
							end
						end else if (expired) begin
							// timeout: resend base..next-1
							idle_timer_q    <= '0;
							timeout_count_q <= toc_inc;
							if (toc_inc > {1'b0, retry_limit_q}) begin
								failed_flag_q <= 1'b1;
							end
							cursor_q <= window_base_q;
							bound_q  <= {1'b0, next_seq_q};
							state_q  <= gbn_pkg::ST_RESEND;
						end else begin
							if (tick_active && outstanding) begin
								idle_timer_q <= timer_inc;
							end
							if (can_send) begin
								idle_timer_q <= '0;
								bound_q      <= send_bound;
								state_q      <= gbn_pkg::ST_SEND;
							end
						end
					end
				end
				gbn_pkg::ST_RESEND: begin
					if (out_free) begin
						cursor_q <= step.seq_inc;
						cnt_q    <= cnt_q + gbn_pkg::CNT_BITS'(1);
						if (step.last) begin
							state_q <= gbn_pkg::ST_IDLE;
						end
					end
				end
				gbn_pkg::ST_SEND: begin
					if (out_free) begin
						next_seq_q <= step.seq_inc;
						cnt_q      <= cnt_q + gbn_pkg::CNT_BITS'(1);
						if (step.last) begin
							state_q <= gbn_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= gbn_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (accept && !expired && !(gbn_pkg::op_t'(op) == gbn_pkg::OP_TICK
				&& can_send)) || (state_q == gbn_pkg::ST_RESEND)
				|| (state_q == gbn_pkg::ST_SEND)
				|| (accept && gbn_pkg::op_t'(op) == gbn_pkg::OP_ACK);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == gbn_pkg::ST_RESEND || state_q == gbn_pkg::ST_SEND) begin
				send_valid_q <= 1'b1;
				send_seq_q   <= step_cursor;
				is_resend_q  <= (state_q == gbn_pkg::ST_RESEND);
				last_q       <= step.last;
				done_q       <= window_base_q >= packet_count_q;
				failed_q     <= failed_flag_q;
			end else begin
				// status result
				send_valid_q <= 1'b0;
				send_seq_q   <= '0;
				is_resend_q  <= 1'b0;
				last_q       <= 1'b1;
				done_q       <= base_after_ack >= packet_count_q;
				failed_q     <= failed_flag_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign send_valid = send_valid_q;
	assign send_seq   = send_seq_q;
	assign is_resend  = is_resend_q;
	assign last       = last_q;
	assign done_res   = done_q;
	assign failed     = failed_q;

endmodule

@@ tb/gbn_window_checker.sv @@
// Scoreboard for the Go-Back-N sender window: mirrors the window state, predicts the
// send, resend and status commands of each transaction and compares them in order.
// Depends on gbn_pkg.
`timescale 1ns / 100ps

module gbn_window_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [gbn_pkg::CFG_BITS-1:0] cfg_wdata,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         op,
	input  logic [gbn_pkg::SEQ_BITS-1:0] ack_number,
	input  logic                         ack_ok,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         send_valid,
	input  logic [gbn_pkg::SEQ_BITS-1:0] send_seq,
	input  logic                         is_resend,
	input  logic                         last,
	input  logic                         done_res,
	input  logic                         failed,
	output int                           mismatch_count,
	output int                           pending_results,
	output int                           results_checked,
	output logic [gbn_pkg::SEQ_BITS-1:0] base_now,
	output logic [gbn_pkg::SEQ_BITS-1:0] next_now
);

	localparam int SB = gbn_pkg::SEQ_BITS;
	localparam int WB = gbn_pkg::WIN_BITS;
	localparam int TB = gbn_pkg::TICK_BITS;

	typedef struct packed {
		logic          xmit;
		logic [SB-1:0] seq;
		logic          resend;
		logic          tail;
		logic          done;
		logic          dead;
	} tx_cmd_t;

	// mirrored configuration
	logic [SB-1:0]                  pkt_total;
	logic [WB-1:0]                  win_req;
	logic [TB-1:0]                  tick_limit;
	logic [gbn_pkg::RETRY_BITS-1:0] retry_max;

	// mirrored window state
	logic [SB-1:0]                base_seq;
	logic [SB-1:0]                send_ptr;
	logic [TB-1:0]                tick_age;
	logic [gbn_pkg::TOC_BITS-1:0] timeouts;
	logic                         gave_up;

	tx_cmd_t expected_cmds[$];

	assign base_now = base_seq;
	assign next_now = send_ptr;

	// Apply one tick or ack to the mirrored window and queue the commands it yields
	task automatic advance_window(input logic is_ack, input logic [SB-1:0] ack_no,
			input logic ok);
		tx_cmd_t      burst[$];
		tx_cmd_t      cmd;
		logic [SB:0]  new_base;
		logic [SB:0]  win_top;
		logic [SB:0]  s;
		logic [WB-1:0] win;
		logic [TB-1:0] lim;
		logic         expired;
		if (is_ack) begin
			if (!gave_up && ok && ack_no >= base_seq) begin
				new_base = {1'b0, ack_no} + 1'b1;
				if (new_base > {1'b0, pkt_total})
					new_base = {1'b0, pkt_total};
				if (new_base > {1'b0, base_seq}) begin
					base_seq = new_base[SB-1:0];
					tick_age = '0;
				end
				// ack ahead of the send pointer drags it along
				if (send_ptr < base_seq)
					send_ptr = base_seq;
			end
		end else if (!gave_up && base_seq < pkt_total) begin
			expired = 1'b0;
			if (send_ptr > base_seq) begin
				lim = (tick_limit == '0) ? TB'(1) : tick_limit;
				if (tick_age != '1)
					tick_age++;
				if (tick_age >= lim)
					expired = 1'b1;
			end
			if (expired) begin
				// timeout: resend the whole outstanding window
				for (s = {1'b0, base_seq};
						s < {1'b0, send_ptr} && burst.size() < gbn_pkg::MAX_WINDOW;
						s++) begin
					cmd = '0;
					cmd.xmit = 1'b1;
					cmd.seq = s[SB-1:0];
					cmd.resend = 1'b1;
					burst.push_back(cmd);
				end
				tick_age = '0;
				if (timeouts != '1)
					timeouts++;
				if (timeouts > retry_max)
					gave_up = 1'b1;
			end else begin
				// fresh sends while window and packet count allow
				win = (win_req == '0) ? WB'(1) :
					(win_req > gbn_pkg::MAX_WINDOW) ? WB'(gbn_pkg::MAX_WINDOW) : win_req;
				win_top = base_seq + win;
				while ({1'b0, send_ptr} < win_top && send_ptr < pkt_total &&
						burst.size() < gbn_pkg::MAX_WINDOW) begin
					cmd = '0;
					cmd.xmit = 1'b1;
					cmd.seq = send_ptr;
					burst.push_back(cmd);
					send_ptr++;
					tick_age = '0;
				end
			end
		end
		if (burst.size() == 0) begin
			cmd = '0;
			burst.push_back(cmd);
		end
		foreach (burst[k]) begin
			burst[k].tail = (k == burst.size() - 1);
			burst[k].done = (base_seq >= pkt_total);
			burst[k].dead = gave_up;
			expected_cmds.push_back(burst[k]);
		end
	endtask

	task automatic check_field(input string name, input logic [SB-1:0] want,
			input logic [SB-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tx_cmd_t want;
		if (!arst_n) begin
			pkt_total = gbn_pkg::PACKET_COUNT_RST;
			win_req = gbn_pkg::WINDOW_SIZE_RST;
			tick_limit = gbn_pkg::TIMEOUT_TICKS_RST;
			retry_max = gbn_pkg::RETRY_LIMIT_RST;
			base_seq = '0;
			send_ptr = '0;
			tick_age = '0;
			timeouts = '0;
			gave_up = 1'b0;
			expected_cmds.delete();
			mismatch_count = 0;
			results_checked = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					gbn_pkg::REG_PACKET_COUNT:  pkt_total = cfg_wdata[SB-1:0];
					gbn_pkg::REG_WINDOW_SIZE:   win_req = cfg_wdata[WB-1:0];
					gbn_pkg::REG_TIMEOUT_TICKS: tick_limit = cfg_wdata[TB-1:0];
					gbn_pkg::REG_RETRY_LIMIT:
						retry_max = cfg_wdata[gbn_pkg::RETRY_BITS-1:0];
					default: ;
				endcase
			end
			// input transaction
			if (in_valid && in_ready)
				advance_window(op == gbn_pkg::OP_ACK, ack_number, ack_ok);
			// output transaction
			if (out_valid && out_ready) begin
				results_checked++;
				if (expected_cmds.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result: expected none, actual seq %0d last %0b",
						$time, send_seq, last);
				end else begin
					want = expected_cmds.pop_front();
					check_field("send_valid", want.xmit, send_valid);
					check_field("send_seq", want.seq, send_seq);
					check_field("is_resend", want.resend, is_resend);
					check_field("last", want.tail, last);
					check_field("done_res", want.done, done_res);
					check_field("failed", want.dead, failed);
				end
			end
		end
		pending_results = expected_cmds.size();
	end

endmodule

@@ tb/go_back_n_sender_window_test.sv @@
// Top of the Go-Back-N sender window testbench: clock, reset, stimulus, register setup,
// output back-pressure, watchdog and verdict. Depends on gbn_pkg, gbn_window_checker
// and go_back_n_sender_window.
`timescale 1ns / 100ps

module go_back_n_sender_window_test;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CHUNK_ITEMS    = 45;
	localparam int SB             = gbn_pkg::SEQ_BITS;
	localparam int CB             = gbn_pkg::CFG_BITS;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [CB-1:0] cfg_wdata;
	logic          in_valid;
	logic          in_ready;
	logic          op;
	logic [SB-1:0] ack_number;
	logic          ack_ok;
	logic          out_valid;
	logic          out_ready;
	logic          send_valid;
	logic [SB-1:0] send_seq;
	logic          is_resend;
	logic          last;
	logic          done_res;
	logic          failed;

	int            mismatches;
	int            pending;
	int            results_seen;
	logic [SB-1:0] base_now;
	logic [SB-1:0] next_now;

	int tx_idle_pct;
	int rx_idle_pct;
	int holds_asked;
	int holds_served;
	int items_sent;
	int stall_cycles;

	go_back_n_sender_window dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.ack_number (ack_number),
		.ack_ok     (ack_ok),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.send_valid (send_valid),
		.send_seq   (send_seq),
		.is_resend  (is_resend),
		.last       (last),
		.done_res   (done_res),
		.failed     (failed)
	);

	gbn_window_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.ack_number      (ack_number),
		.ack_ok          (ack_ok),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.send_valid      (send_valid),
		.send_seq        (send_seq),
		.is_resend       (is_resend),
		.last            (last),
		.done_res        (done_res),
		.failed          (failed),
		.mismatch_count  (mismatches),
		.pending_results (pending),
		.results_checked (results_seen),
		.base_now        (base_now),
		.next_now        (next_now)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output side: random stalls, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: ends the run if no transaction moves for too long
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Drive one input transaction; called right after a falling edge
	task automatic offer(input gbn_pkg::op_t o, input logic [SB-1:0] a, input logic k);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		ack_number <= a;
		ack_ok <= k;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic item(input gbn_pkg::op_t o, input logic [SB-1:0] a, input logic k);
		@(negedge clk);
		offer(o, a, k);
	endtask

	task automatic write_reg(input gbn_pkg::cfg_reg_t idx, input logic [CB-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every predicted result has been taken
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	function automatic logic [SB-1:0] pkt_above_base(input int extra);
		logic [SB:0] pc;
		pc = {1'b0, base_now} + (SB+1)'(extra);
		if (pc > {1'b0, {SB{1'b1}}})
			pc = {1'b0, {SB{1'b1}}};
		return pc[SB-1:0];
	endfunction

	// New settings between random chunks, transfer extended past the current base
	task automatic retune();
		int w;
		write_reg(gbn_pkg::REG_PACKET_COUNT, pkt_above_base($urandom_range(400, 40)));
		case ($urandom_range(4))
			0: w = 0;
			1: w = 1;
			2: w = gbn_pkg::MAX_WINDOW;
			3: w = $urandom_range(127, 65);
			default: w = $urandom_range(63, 2);
		endcase
		write_reg(gbn_pkg::REG_WINDOW_SIZE, CB'(w));
		write_reg(gbn_pkg::REG_TIMEOUT_TICKS, CB'($urandom_range(12, 3)));
	endtask

	// Mostly ticks and plausible acks around the window, some pure noise
	task automatic random_item();
		int pick;
		logic [SB-1:0] span;
		logic [SB-1:0] a;
		@(negedge clk);
		pick = $urandom_range(99);
		span = next_now - base_now;
		if (pick < 45) begin
			offer(gbn_pkg::OP_TICK, SB'($urandom), 1'($urandom));
		end else if (pick < 85) begin
			if (base_now == '0)
				a = SB'($urandom_range(span));
			else
				a = base_now + SB'($urandom_range(span + 1)) - 1'b1;
			offer(gbn_pkg::OP_ACK, a, $urandom_range(9) != 0);
		end else begin
			offer(gbn_pkg::OP_ACK, SB'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_index = gbn_pkg::REG_PACKET_COUNT;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = gbn_pkg::OP_TICK;
		ack_number = '0;
		ack_ok = 1'b0;
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		holds_asked = 0;
		items_sent = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: nothing queued, so status only
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_ACK, '0, 1'b1);
		settle();

		// zero window and zero timeout both act as one
		write_reg(gbn_pkg::REG_RETRY_LIMIT, 16'd255);
		write_reg(gbn_pkg::REG_TIMEOUT_TICKS, 16'd0);
		write_reg(gbn_pkg::REG_WINDOW_SIZE, 16'd0);
		write_reg(gbn_pkg::REG_PACKET_COUNT, 16'hFFFF);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_ACK, '0, 1'b0);
		item(gbn_pkg::OP_ACK, '0, 1'b1);
		item(gbn_pkg::OP_TICK, 16'hFFFF, 1'b1);
		item(gbn_pkg::OP_ACK, 16'd5, 1'b1);
		settle();

		// oversized window clamps to the maximum: one full burst
		write_reg(gbn_pkg::REG_WINDOW_SIZE, 16'd127);
		write_reg(gbn_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_ACK, 16'd3, 1'b1);
		item(gbn_pkg::OP_ACK, 16'hFFFF, 1'b0);
		settle();

		// full-window resend, then a huge ack clamps base to the packet count
		write_reg(gbn_pkg::REG_PACKET_COUNT, 16'd100);
		write_reg(gbn_pkg::REG_WINDOW_SIZE, 16'd64);
		write_reg(gbn_pkg::REG_TIMEOUT_TICKS, 16'd2);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_ACK, 16'hFFFF, 1'b1);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		settle();

		// packet count dropped below base: still done
		write_reg(gbn_pkg::REG_PACKET_COUNT, 16'd50);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		settle();

		// transfer resumed, partial ack, then timeout of the remainder
		write_reg(gbn_pkg::REG_PACKET_COUNT, 16'd300);
		write_reg(gbn_pkg::REG_TIMEOUT_TICKS, 16'd1);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_ACK, 16'd120, 1'b1);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		settle();

		// random traffic under three idling profiles
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin tx_idle_pct = 29; rx_idle_pct = 84; end
				1: begin tx_idle_pct = 84; rx_idle_pct = 29; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int chunk = 0; chunk < 3; chunk++) begin
				retune();
				for (int i = 0; i < CHUNK_ITEMS; i++) begin
					// long output hold-off while input keeps coming
					if (mode == 2 && chunk == 1 && i == 10)
						holds_asked++;
					random_item();
				end
				settle();
			end
		end

		// retry limit of zero: the next timeout fails the transfer
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		write_reg(gbn_pkg::REG_RETRY_LIMIT, 16'd0);
		write_reg(gbn_pkg::REG_TIMEOUT_TICKS, 16'd1);
		write_reg(gbn_pkg::REG_WINDOW_SIZE, 16'd1);
		write_reg(gbn_pkg::REG_PACKET_COUNT, pkt_above_base(100));
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		item(gbn_pkg::OP_ACK, base_now, 1'b1);
		item(gbn_pkg::OP_TICK, '0, 1'b0);
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d input and %0d result transactions: window, timeout and",
			items_sent, results_seen);
		$display("packet count extremes, three stall profiles, a long output hold-off, failure.");
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
